@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Every check runs on the rising edge
// of clk and is switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// general property check
`define TSS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tilemap scroll check failed");

// same-cycle implication check
`define TSS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tilemap scroll implication failed");

`endif

@@ sv/tss_pkg.sv @@
// ----------------------------------------------------------------------------
// tss_pkg
// Types and constants of the tilemap scroll streamer.
// ----------------------------------------------------------------------------
package tss_pkg;

  // screen size in tiles
  localparam logic [11:0] SCREEN_COLS = 12'd28;
  localparam logic [11:0] SCREEN_ROWS = 12'd28;

  // level size after reset
  localparam logic [11:0] LEVEL_RESET = 12'd28;

  // two header bytes precede the tile data
  localparam logic [15:0] HDR_OFFSET = 16'd2;

  // tiles drawn from the first map row or column on (vram depth minus two)
  localparam logic [4:0] MAIN_SPAN = 5'd30;

  // draw step codes: newly exposed line ahead or behind the camera
  localparam logic [4:0] STEP_FWD  = 5'd29;
  localparam logic [4:0] STEP_BACK = 5'd30;

  // item kinds
  localparam logic KIND_MOVE = 1'b0;
  localparam logic KIND_FILL = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_LEVEL_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_LEVEL_HEIGHT = 2'd1;

  // sequencer states
  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_CLAMP     = 9'b000000010,
    S_SETUP     = 9'b000000100,
    S_BASE      = 9'b000001000,
    S_MAIN      = 9'b000010000,
    S_EDGE_PREP = 9'b000100000,
    S_EDGE2     = 9'b001000000,
    S_EDGE1     = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_t;

  // one tile copy command
  typedef struct packed {
    logic [4:0]  col;
    logic [4:0]  row;
    logic [15:0] addr;
  } tile_cmd_t;

  // map line offset from the camera tile for a draw step code:
  // codes up to 29 are forward, 30 and 31 are the two wrap lines behind
  function automatic logic signed [5:0] step_offset(input logic [4:0] k);
    logic signed [5:0] res;
    res = $signed({1'b0, k});
    if (k >= 5'd30) begin
      res = $signed({1'b1, k});
    end
    return res;
  endfunction

endpackage

@@ sv/tilemap_scroll_streamer.sv @@
// ----------------------------------------------------------------------------
// tilemap_scroll_streamer
// Scroll camera over a tile map kept in a 32x32 circular video memory.
// ----------------------------------------------------------------------------
// A move item clamps the camera to the level, updates the scroll values and,
// when a tile boundary is crossed, streams copy commands for the newly exposed
// column and/or row; a fill item streams one initial column. Items are handled
// one at a time: in_stall is high from acceptance until the final result is
// loaded into the output register. A line that lies outside the level draws
// nothing; any other line draws up to 30 main tiles. The pace is set by the
// single address adder, which steps one tile command per cycle while the
// output is not stalled. An item that draws nothing yields one result with
// write_valid low. Configuration writes are always taken (cfg_ready is high)
// and must only occur while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tilemap_scroll_streamer (
  input  logic               clk,
  input  logic               rst_n,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic signed [15:0] in_target_x,
  input  logic signed [15:0] in_target_y,
  input  logic [4:0]         in_fill_step,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_write_valid,
  output logic [4:0]         out_vram_col,
  output logic [4:0]         out_vram_row,
  output logic [15:0]        out_map_addr,
  output logic [7:0]         out_scroll_x,
  output logic [7:0]         out_scroll_y,
  output logic               out_last,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data
);

  tss_pkg::state_t state_r;

  logic [11:0] level_w_r, level_h_r;
  logic [14:0] cam_x_r, cam_y_r;

  // latched input item
  logic               kind_r;
  logic signed [15:0] tx_r, ty_r;
  logic [4:0]         fstep_r;

  // pending draws
  logic       need_col_r, need_row_r;
  logic [4:0] col_k_r, row_k_r;

  // current draw job
  logic        axis_col_r;
  logic [4:0]  fix_r;
  logic [11:0] s_r, lim_r, r_r, stride_r;
  logic        job_ok_r;
  logic [15:0] base_r, acc_r;
  logic [4:0]  cnt_r;

  // held and output results
  logic                hold_v_r;
  tss_pkg::tile_cmd_t  hold_r;
  logic                out_v_r;
  tss_pkg::tile_cmd_t  out_cmd_r;
  logic                out_wv_r, out_last_r;
  logic [7:0]          out_sx_r, out_sy_r;

  // camera tile coordinates
  logic [11:0] cxt, cyt;
  assign cxt = cam_x_r[14:3];
  assign cyt = cam_y_r[14:3];

  // clamp of the requested camera position
  logic signed [12:0] span_x, span_y;
  logic [14:0]        max_x, max_y, clamp_x, clamp_y;
  assign span_x = $signed({1'b0, level_w_r}) - $signed({1'b0, tss_pkg::SCREEN_COLS});
  assign span_y = $signed({1'b0, level_h_r}) - $signed({1'b0, tss_pkg::SCREEN_ROWS});
  assign max_x  = span_x[12] ? 15'd0 : {span_x[11:0], 3'b000};
  assign max_y  = span_y[12] ? 15'd0 : {span_y[11:0], 3'b000};

  always_comb begin
    if (tx_r[15]) begin
      clamp_x = 15'd0;
    end else if (tx_r[14:0] > max_x) begin
      clamp_x = max_x;
    end else begin
      clamp_x = tx_r[14:0];
    end
    if (ty_r[15]) begin
      clamp_y = 15'd0;
    end else if (ty_r[14:0] > max_y) begin
      clamp_y = max_y;
    end else begin
      clamp_y = ty_r[14:0];
    end
  end

  // tile boundary crossing and direction by the shorter wrapped distance
  logic [7:0] dfx, dbx, dfy, dby;
  logic       cross_x, cross_y;
  assign dfx     = clamp_x[7:0] - cam_x_r[7:0];
  assign dbx     = cam_x_r[7:0] - clamp_x[7:0];
  assign dfy     = clamp_y[7:0] - cam_y_r[7:0];
  assign dby     = cam_y_r[7:0] - clamp_y[7:0];
  assign cross_x = clamp_x[7:3] != cam_x_r[7:3];
  assign cross_y = clamp_y[7:3] != cam_y_r[7:3];

  // job selection for the next draw
  logic [4:0]         job_k;
  logic [11:0]        job_t, job_s, job_lim, job_bound;
  logic signed [13:0] job_r;
  logic               job_ok;
  assign job_k     = need_col_r ? col_k_r : row_k_r;
  assign job_t     = need_col_r ? cxt : cyt;
  assign job_s     = need_col_r ? cyt : cxt;
  assign job_lim   = need_col_r ? level_h_r : level_w_r;
  assign job_bound = need_col_r ? level_w_r : level_h_r;
  assign job_r     = $signed({2'b00, job_t}) + 14'(tss_pkg::step_offset(job_k));
  assign job_ok    = !job_r[13] && (job_r[12:0] < {1'b0, job_bound});

  // base address of the line's first main tile, header included
  logic [11:0] m_a, m_b;
  logic [23:0] prod;
  logic [15:0] base_nxt;
  assign m_a      = axis_col_r ? s_r : r_r;
  assign m_b      = axis_col_r ? r_r : s_r;
  assign prod     = m_a * level_w_r;
  assign base_nxt = prod[15:0] + {4'b0000, m_b} + tss_pkg::HDR_OFFSET;

  // shared address adder
  logic [15:0] add_a, add_b, add_sum;
  always_comb begin
    if (state_r == tss_pkg::S_EDGE_PREP) begin
      add_a = base_r;
      add_b = 16'd0 - {3'b000, stride_r, 1'b0};
    end else begin
      add_a = acc_r;
      add_b = {4'b0000, stride_r};
    end
  end
  assign add_sum = add_a + add_b;

  // main tile position along the line
  logic [12:0] my;
  logic        main_go;
  assign my      = {1'b0, s_r} + {8'd0, cnt_r};
  assign main_go = (cnt_r < tss_pkg::MAIN_SPAN) && (my < {1'b0, lim_r});

  // output handshake
  logic out_free, can_put, put_en, flush_en, out_load;
  logic edge2_go, edge1_go;
  assign out_free = !out_v_r || !out_stall;
  assign can_put  = !hold_v_r || out_free;
  assign edge2_go = s_r > 12'd1;
  assign edge1_go = s_r != 12'd0;
  assign put_en   = can_put && (((state_r == tss_pkg::S_MAIN) && main_go) ||
                                ((state_r == tss_pkg::S_EDGE2) && edge2_go) ||
                                ((state_r == tss_pkg::S_EDGE1) && edge1_go));
  assign flush_en = (state_r == tss_pkg::S_DONE) && out_free;
  assign out_load = flush_en || (put_en && hold_v_r);

  // command being produced
  logic [4:0]         along;
  tss_pkg::tile_cmd_t put_cmd;
  always_comb begin
    case (state_r)
      tss_pkg::S_MAIN:  along = my[4:0];
      tss_pkg::S_EDGE2: along = s_r[4:0] - 5'd2;
      default:          along = s_r[4:0] - 5'd1;
    endcase
    put_cmd.col  = axis_col_r ? fix_r : along;
    put_cmd.row  = axis_col_r ? along : fix_r;
    put_cmd.addr = acc_r;
  end

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_w_r <= tss_pkg::LEVEL_RESET;
      level_h_r <= tss_pkg::LEVEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tss_pkg::CFG_LEVEL_WIDTH:  level_w_r <= cfg_data;
        tss_pkg::CFG_LEVEL_HEIGHT: level_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  assign in_stall = state_r != tss_pkg::S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tss_pkg::S_IDLE;
      cam_x_r    <= 15'd0;
      cam_y_r    <= 15'd0;
      need_col_r <= 1'b0;
      need_row_r <= 1'b0;
    end else begin
      case (state_r)
        tss_pkg::S_IDLE: begin
          if (in_valid) begin
            state_r <= tss_pkg::S_CLAMP;
          end
        end
        tss_pkg::S_CLAMP: begin
          if (kind_r == tss_pkg::KIND_MOVE) begin
            cam_x_r    <= clamp_x;
            cam_y_r    <= clamp_y;
            need_col_r <= cross_x;
            need_row_r <= cross_y;
          end else begin
            need_col_r <= 1'b1;
            need_row_r <= 1'b0;
          end
          state_r <= tss_pkg::S_SETUP;
        end
        tss_pkg::S_SETUP: begin
          if (need_col_r) begin
            need_col_r <= 1'b0;
            state_r    <= tss_pkg::S_BASE;
          end else if (need_row_r) begin
            need_row_r <= 1'b0;
            state_r    <= tss_pkg::S_BASE;
          end else begin
            state_r <= tss_pkg::S_DONE;
          end
        end
        tss_pkg::S_BASE: begin
          state_r <= job_ok_r ? tss_pkg::S_MAIN : tss_pkg::S_SETUP;
        end
        tss_pkg::S_MAIN: begin
          if (!main_go) begin
            state_r <= tss_pkg::S_EDGE_PREP;
          end
        end
        tss_pkg::S_EDGE_PREP: begin
          state_r <= tss_pkg::S_EDGE2;
        end
        tss_pkg::S_EDGE2: begin
          if (!edge2_go || can_put) begin
            state_r <= tss_pkg::S_EDGE1;
          end
        end
        tss_pkg::S_EDGE1: begin
          if (!edge1_go || can_put) begin
            state_r <= tss_pkg::S_SETUP;
          end
        end
        tss_pkg::S_DONE: begin
          if (out_free) begin
            state_r <= tss_pkg::S_IDLE;
          end
        end
        default: begin
          state_r <= tss_pkg::S_IDLE;
        end
      endcase
    end
  end

  // datapath registers of the sequencer
  always_ff @(posedge clk) begin
    // item capture
    if ((state_r == tss_pkg::S_IDLE) && in_valid) begin
      kind_r  <= in_kind;
      tx_r    <= in_target_x;
      ty_r    <= in_target_y;
      fstep_r <= in_fill_step;
    end
    // draw step codes
    if (state_r == tss_pkg::S_CLAMP) begin
      if (kind_r == tss_pkg::KIND_MOVE) begin
        col_k_r <= (dfx < dbx) ? tss_pkg::STEP_FWD : tss_pkg::STEP_BACK;
        row_k_r <= (dfy < dby) ? tss_pkg::STEP_FWD : tss_pkg::STEP_BACK;
      end else begin
        col_k_r <= fstep_r;
      end
    end
    // job parameters
    if (state_r == tss_pkg::S_SETUP) begin
      axis_col_r <= need_col_r;
      fix_r      <= job_t[4:0] + job_k;
      s_r        <= job_s;
      lim_r      <= job_lim;
      r_r        <= job_r[11:0];
      job_ok_r   <= job_ok;
      stride_r   <= need_col_r ? level_w_r : 12'd1;
    end
    // base address, counter and running address
    if (state_r == tss_pkg::S_BASE) begin
      base_r <= base_nxt;
      acc_r  <= base_nxt;
      cnt_r  <= 5'd0;
    end
    if ((state_r == tss_pkg::S_MAIN) && main_go && can_put) begin
      acc_r <= add_sum;
      cnt_r <= cnt_r + 5'd1;
    end
    if ((state_r == tss_pkg::S_EDGE_PREP) ||
        ((state_r == tss_pkg::S_EDGE2) && (!edge2_go || can_put))) begin
      acc_r <= add_sum;
    end
  end

  // held result and output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (flush_en) begin
        hold_v_r <= 1'b0;
      end else if (put_en) begin
        hold_v_r <= 1'b1;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // held result and output payload
  always_ff @(posedge clk) begin
    if (put_en) begin
      hold_r <= put_cmd;
    end
    if (out_load) begin
      out_sx_r <= cam_x_r[7:0];
      out_sy_r <= cam_y_r[7:0];
      if (flush_en) begin
        out_last_r <= 1'b1;
        out_wv_r   <= hold_v_r;
        out_cmd_r  <= hold_v_r ? hold_r : '0;
      end else begin
        out_last_r <= 1'b0;
        out_wv_r   <= 1'b1;
        out_cmd_r  <= hold_r;
      end
    end
  end

  assign out_valid       = out_v_r;
  assign out_write_valid = out_wv_r;
  assign out_vram_col    = out_cmd_r.col;
  assign out_vram_row    = out_cmd_r.row;
  assign out_map_addr    = out_cmd_r.addr;
  assign out_scroll_x    = out_sx_r;
  assign out_scroll_y    = out_sy_r;
  assign out_last        = out_last_r;

  // checks
  `TSS_ASSERT_IMPL(a_idle_no_hold, state_r == tss_pkg::S_IDLE, !hold_v_r)
  `TSS_ASSERT_IMPL(a_main_job_ok, state_r == tss_pkg::S_MAIN, job_ok_r)
  `TSS_ASSERT_IMPL(a_empty_is_last, out_v_r && !out_wv_r, out_last_r)
  `TSS_ASSERT(a_accept_to_clamp, (in_valid && !in_stall) |=> (state_r == tss_pkg::S_CLAMP))

endmodule

@@ tb/tss_checker.sv @@
// ----------------------------------------------------------------------------
// tss_checker
// Watches the item, result and register channels of the tilemap scroll
// streamer, works out the tile copy commands each item should cause and
// compares every result against the oldest one still owed.
// ----------------------------------------------------------------------------
module tss_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_kind,
  input  logic signed [15:0] in_target_x,
  input  logic signed [15:0] in_target_y,
  input  logic [4:0]         in_fill_step,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_write_valid,
  input  logic [4:0]         out_vram_col,
  input  logic [4:0]         out_vram_row,
  input  logic [15:0]        out_map_addr,
  input  logic [7:0]         out_scroll_x,
  input  logic [7:0]         out_scroll_y,
  input  logic               out_last,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  output int                 mismatches,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TILE_PX     = 8;
  localparam int VRAM_DIM    = 32;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic        wr;
    logic [4:0]  col;
    logic [4:0]  row;
    logic [15:0] addr;
    logic [7:0]  sx;
    logic [7:0]  sy;
    logic        last;
  } tile_result_t;

  // mirrored block state
  logic [11:0]  level_w;
  logic [11:0]  level_h;
  logic [15:0]  camera_x_q;
  logic [15:0]  camera_y_q;
  logic [7:0]   scroll_x_q;
  logic [7:0]   scroll_y_q;
  tile_result_t tile_q[$];
  int           err_count = 0;

  // one tile copy command at the current scroll values
  function automatic void push_tile(input int col, input int row, input int idx);
    tile_result_t r;
    r.wr   = 1'b1;
    r.col  = col[4:0];
    r.row  = row[4:0];
    r.addr = idx[15:0] + tss_pkg::HDR_OFFSET;
    r.sx   = scroll_x_q;
    r.sy   = scroll_y_q;
    r.last = 1'b0;
    tile_q.push_back(r);
  endfunction

  // map column r, starting at map row y, into vram column x
  function automatic void draw_column(input int x, input int y, input int r);
    int w;
    int h;
    int my;
    w = level_w;
    h = level_h;
    if (r < 0 || r >= w || y < 0) begin
      return;
    end
    for (int i = 0; i < VRAM_DIM - 2; i++) begin
      my = y + i;
      if (my >= h) begin
        break;
      end
      push_tile(x, my, my * w + r);
    end
    // two wrap tiles above the first row
    if (y > 1) begin
      push_tile(x, y + VRAM_DIM - 2, (y - 2) * w + r);
    end
    if (y > 0) begin
      push_tile(x, y + VRAM_DIM - 1, (y - 1) * w + r);
    end
  endfunction

  // map row r, starting at map column x, into vram row y
  function automatic void draw_row(input int x, input int y, input int r);
    int w;
    int h;
    int mx;
    w = level_w;
    h = level_h;
    if (r < 0 || r >= h || x < 0) begin
      return;
    end
    for (int i = 0; i < VRAM_DIM - 2; i++) begin
      mx = x + i;
      if (mx >= w) begin
        break;
      end
      push_tile(mx, y, r * w + mx);
    end
    // two wrap tiles left of the first column
    if (x > 1) begin
      push_tile(x + VRAM_DIM - 2, y, r * w + x - 2);
    end
    if (x > 0) begin
      push_tile(x + VRAM_DIM - 1, y, r * w + x - 1);
    end
  endfunction

  // clamp a requested pixel position into the level, max floored at zero
  function automatic logic [15:0] clamp_camera(input logic signed [15:0] req,
                                               input logic [11:0] size,
                                               input logic [11:0] screen);
    int v;
    int limit_px;
    v = req;
    limit_px = (int'(size) - int'(screen)) * TILE_PX;
    if (limit_px < 0) begin
      limit_px = 0;
    end
    if (v < 0) begin
      return '0;
    end
    if (v > limit_px) begin
      return limit_px[15:0];
    end
    return v[15:0];
  endfunction

  // expected tile commands of one item
  function automatic void predict_tiles(input logic kind,
                                        input logic signed [15:0] tx,
                                        input logic signed [15:0] ty,
                                        input logic [4:0] step);
    logic [7:0]   prev_x;
    logic [7:0]   prev_y;
    logic [7:0]   fwd_d;
    logic [7:0]   back_d;
    int           cxt;
    int           cyt;
    int           s;
    int           start_n;
    tile_result_t r;
    start_n = tile_q.size();
    if (kind == tss_pkg::KIND_MOVE) begin
      prev_x     = scroll_x_q;
      prev_y     = scroll_y_q;
      camera_x_q = clamp_camera(tx, level_w, tss_pkg::SCREEN_COLS);
      camera_y_q = clamp_camera(ty, level_h, tss_pkg::SCREEN_ROWS);
      scroll_x_q = camera_x_q[7:0];
      scroll_y_q = camera_y_q[7:0];
      cxt = int'(camera_x_q) / TILE_PX;
      cyt = int'(camera_y_q) / TILE_PX;
      // horizontal tile crossing, direction by shorter wrapped distance
      if (prev_x[7:3] != scroll_x_q[7:3]) begin
        fwd_d  = scroll_x_q - prev_x;
        back_d = prev_x - scroll_x_q;
        if (fwd_d < back_d) begin
          draw_column(cxt + VRAM_DIM - 3, cyt, cxt + VRAM_DIM - 3);
        end else begin
          draw_column(cxt + VRAM_DIM - 2, cyt, cxt - 2);
        end
      end
      // vertical tile crossing
      if (prev_y[7:3] != scroll_y_q[7:3]) begin
        fwd_d  = scroll_y_q - prev_y;
        back_d = prev_y - scroll_y_q;
        if (fwd_d < back_d) begin
          draw_row(cxt, cyt + VRAM_DIM - 3, cyt + VRAM_DIM - 3);
        end else begin
          draw_row(cxt, cyt + VRAM_DIM - 2, cyt - 2);
        end
      end
    end else begin
      s   = step;
      cxt = int'(camera_x_q) / TILE_PX;
      cyt = int'(camera_y_q) / TILE_PX;
      // steps past the main span fill the left wrap columns
      if (s < VRAM_DIM - 2) begin
        draw_column(cxt + s, cyt, cxt + s);
      end else if (s == VRAM_DIM - 2) begin
        draw_column(cxt + VRAM_DIM - 2, cyt, cxt - 2);
      end else begin
        draw_column(cxt + VRAM_DIM - 1, cyt, cxt - 1);
      end
    end
    // nothing drawn gives a single empty result
    if (tile_q.size() == start_n) begin
      r      = '0;
      r.sx   = scroll_x_q;
      r.sy   = scroll_y_q;
      r.last = 1'b1;
      tile_q.push_back(r);
    end else begin
      r      = tile_q.pop_back();
      r.last = 1'b1;
      tile_q.push_back(r);
    end
  endfunction

  task automatic flag_error(input string what, input tile_result_t want,
                            input tile_result_t got);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("%0t tss_checker: %s", $time, what);
      $display("  expected wr=%0b col=%0d row=%0d addr=%h sx=%0d sy=%0d last=%0b",
               want.wr, want.col, want.row, want.addr, want.sx, want.sy, want.last);
      $display("  actual   wr=%0b col=%0d row=%0d addr=%h sx=%0d sy=%0d last=%0b",
               got.wr, got.col, got.row, got.addr, got.sx, got.sy, got.last);
    end
  endtask

  // channel monitor
  always @(posedge clk) begin
    tile_result_t got;
    tile_result_t want;
    if (!rst_n) begin
      level_w    = tss_pkg::LEVEL_RESET;
      level_h    = tss_pkg::LEVEL_RESET;
      camera_x_q = '0;
      camera_y_q = '0;
      scroll_x_q = '0;
      scroll_y_q = '0;
      tile_q.delete();
    end else begin
      // result compare against oldest expectation
      if (out_valid && !out_stall) begin
        got = {out_write_valid, out_vram_col, out_vram_row, out_map_addr,
               out_scroll_x, out_scroll_y, out_last};
        if (tile_q.size() == 0) begin
          flag_error("result with nothing expected", '0, got);
        end else begin
          want = tile_q.pop_front();
          if (got !== want) begin
            flag_error("result mismatch", want, got);
          end
        end
      end
      // register writes, unknown indexes ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tss_pkg::CFG_LEVEL_WIDTH:  level_w = cfg_data;
          tss_pkg::CFG_LEVEL_HEIGHT: level_h = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_tiles(in_kind, in_target_x, in_target_y, in_fill_step);
      end
    end
    pending    <= tile_q.size();
    mismatches <= err_count;
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the tilemap scroll streamer: a directed pass over
// clamping, tile crossings, fills and address wrap, then random camera walks
// and jumps under changing level sizes with random idle and stall cycles.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         IDLE_PCT        = 11;
  localparam int         CFG_GAP         = 4;
  localparam int         DRAIN_CYCLES    = 80;
  localparam int         RAND_PHASES     = 5;
  localparam int         ITEMS_PER_PHASE = 16;
  localparam int         CALM_PHASE      = 2;
  localparam int         WALK_SLACK      = 8;
  localparam logic [1:0] CFG_UNUSED      = 2'd3;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic               in_kind      = tss_pkg::KIND_MOVE;
  logic signed [15:0] in_target_x  = '0;
  logic signed [15:0] in_target_y  = '0;
  logic [4:0]         in_fill_step = '0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic               out_write_valid;
  logic [4:0]         out_vram_col;
  logic [4:0]         out_vram_row;
  logic [15:0]        out_map_addr;
  logic [7:0]         out_scroll_x;
  logic [7:0]         out_scroll_y;
  logic               out_last;
  logic               cfg_valid    = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index    = tss_pkg::CFG_LEVEL_WIDTH;
  logic [11:0]        cfg_data     = '0;
  logic               calm         = 1'b0;
  int                 mismatches;
  int                 pending;

  // stimulus-side view of the level, used to steer the walk
  int lvl_w = 28;
  int lvl_h = 28;
  int aim_x = 0;
  int aim_y = 0;

  tilemap_scroll_streamer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_target_x(in_target_x), .in_target_y(in_target_y),
    .in_fill_step(in_fill_step),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_write_valid(out_write_valid), .out_vram_col(out_vram_col),
    .out_vram_row(out_vram_row), .out_map_addr(out_map_addr),
    .out_scroll_x(out_scroll_x), .out_scroll_y(out_scroll_y),
    .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tss_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_target_x(in_target_x), .in_target_y(in_target_y),
    .in_fill_step(in_fill_step),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_write_valid(out_write_valid), .out_vram_col(out_vram_col),
    .out_vram_row(out_vram_row), .out_map_addr(out_map_addr),
    .out_scroll_x(out_scroll_x), .out_scroll_y(out_scroll_y),
    .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // result-side back pressure, none during the calm stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // present one item and hold it until taken
  task automatic send_item(input logic kind, input logic signed [15:0] tx,
                           input logic signed [15:0] ty, input logic [4:0] step);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_target_x  <= tx;
    in_target_y  <= ty;
    in_fill_step <= step;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic move_cam(input logic signed [15:0] tx, input logic signed [15:0] ty);
    send_item(tss_pkg::KIND_MOVE, tx, ty, 5'($urandom));
  endtask

  task automatic fill_col(input logic [4:0] step);
    send_item(tss_pkg::KIND_FILL, 16'($urandom), 16'($urandom), step);
  endtask

  // stop sending and wait until every owed result has come back
  task automatic wait_idle(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // new level size, plus a write to an index the block ignores
  task automatic set_level(input logic [11:0] w, input logic [11:0] h);
    wait_idle(CFG_GAP);
    write_reg(tss_pkg::CFG_LEVEL_WIDTH, w);
    write_reg(tss_pkg::CFG_LEVEL_HEIGHT, h);
    write_reg(CFG_UNUSED, 12'($urandom));
    cfg_valid <= 1'b0;
    lvl_w = w;
    lvl_h = h;
  endtask

  function automatic logic [11:0] pick_size();
    case ($urandom_range(0, 5))
      0:       return 12'($urandom_range(0, 27));
      1:       return tss_pkg::SCREEN_COLS;
      2:       return 12'd2048;
      3:       return 12'hFFF;
      default: return 12'($urandom_range(29, 300));
    endcase
  endfunction

  function automatic int keep_near(input int v, input int lim);
    if (v < -WALK_SLACK) begin
      return -WALK_SLACK;
    end
    if (v > lim + WALK_SLACK) begin
      return lim + WALK_SLACK;
    end
    return v;
  endfunction

  // mostly short camera walks, some fills and wild jumps
  task automatic random_item();
    int pick;
    int lim_x;
    int lim_y;
    logic [15:0] tx;
    logic [15:0] ty;
    lim_x = (lvl_w > 28) ? (lvl_w - 28) * 8 : 0;
    lim_y = (lvl_h > 28) ? (lvl_h - 28) * 8 : 0;
    pick  = $urandom_range(0, 99);
    if (pick < 15) begin
      fill_col(5'($urandom));
    end else if (pick < 25) begin
      tx = 16'($urandom);
      ty = 16'($urandom);
      move_cam(tx, ty);
      aim_x = keep_near($signed(tx), lim_x);
      aim_y = keep_near($signed(ty), lim_y);
    end else if (pick < 32) begin
      aim_x = $urandom_range(0, lim_x);
      aim_y = $urandom_range(0, lim_y);
      move_cam(16'(aim_x), 16'(aim_y));
    end else begin
      aim_x = keep_near(aim_x + int'($urandom_range(0, 40)) - 20, lim_x);
      aim_y = keep_near(aim_y + int'($urandom_range(0, 40)) - 20, lim_y);
      move_cam(16'(aim_x), 16'(aim_y));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset level equals the screen: camera pinned, only fills draw
    move_cam(-16'sd32768, 16'sd32767);
    fill_col(5'd0);
    fill_col(5'd29);
    fill_col(5'd30);
    fill_col(5'd31);

    // large level: crossings both ways, clamp at max, scroll wrap at 256
    set_level(12'd2048, 12'd2048);
    move_cam(16'sd8, 16'sd0);
    move_cam(16'sd0, 16'sd8);
    move_cam(16'sd7, 16'sd7);
    move_cam(16'sd32767, 16'sd32767);
    fill_col(5'd0);
    fill_col(5'd29);
    fill_col(5'd31);
    move_cam(16'sd248, 16'sd248);
    move_cam(16'sd256, 16'sd256);
    move_cam(16'sd248, 16'sd248);
    move_cam(16'sd250, 16'sd251);
    move_cam(-16'sd1, -16'sd1);

    // widest level: map address wraps past 16 bits
    set_level(12'hFFF, 12'hFFF);
    move_cam(16'sd32767, 16'sd32767);
    fill_col(5'd15);
    move_cam(16'sd32528, 16'sd32528);

    // level smaller than the screen
    set_level(12'd10, 12'd5);
    move_cam(16'sd100, 16'sd100);
    fill_col(5'd5);
    fill_col(5'd30);

    // random phases, one of them without any idling
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_level(pick_size(), pick_size());
      calm <= (ph == CALM_PHASE);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        random_item();
      end
    end

    wait_idle(DRAIN_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
